// ===== src/dve_pkg.sv =====
// ----------------------------------------------------------------------------
// dve_pkg: shared types and constants for the delta varint encoder
// Holds the channel payload structs, the sequencer states and the codes
// of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package dve_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MAX_BYTES  = 5;
  localparam int unsigned CNT_W      = $clog2(MAX_BYTES);

  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_BYTES - 1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_GROUP,
    ST_EMIT
  } dve_state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_SHIFT_DEC
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
  } alu_req_t;

endpackage

// ===== src/dve_alu.sv =====
// ----------------------------------------------------------------------------
// dve_alu: shared subtract unit
// One 32-bit subtractor that serves both the delta difference and the
// shift-and-decrement step between 7-bit groups.
// ----------------------------------------------------------------------------
module dve_alu (
  input  dve_pkg::alu_req_t              req,
  output logic [dve_pkg::VALUE_W-1:0]    result
);
  import dve_pkg::*;

  logic [VALUE_W-1:0] op_a;
  logic [VALUE_W-1:0] op_b;

  always_comb begin
    unique case (req.op)
      ALU_SUB: begin
        op_a = req.a;
        op_b = req.b;
      end
      ALU_SHIFT_DEC: begin
        op_a = req.a >> GROUP_BITS;
        op_b = VALUE_W'(1);
      end
      default: begin
        op_a = req.a;
        op_b = req.b;
      end
    endcase
  end

  assign result = op_a - op_b;

endmodule

// ===== src/dve_ctrl.sv =====
// ----------------------------------------------------------------------------
// dve_ctrl: encoder sequencer and datapath registers
// Takes one value, forms the coded word, peels off 7-bit groups one per
// cycle through the shared subtractor, then sends the bytes high group first.
// ----------------------------------------------------------------------------
module dve_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  delta_mode,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dve_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dve_pkg::out_item_t    out_data
);
  import dve_pkg::*;

  dve_state_t                state_r, state_nxt;
  logic [VALUE_W-1:0]        val_r, val_nxt;
  logic [VALUE_W-1:0]        orig_r, orig_nxt;
  logic [VALUE_W-1:0]        prev_r, prev_nxt;
  logic                      restart_r, restart_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [GROUP_BITS-1:0]     bytes_r [MAX_BYTES];
  logic                      byte_we;

  alu_req_t                  alu_req;
  logic [VALUE_W-1:0]        alu_result;
  logic [VALUE_W-1:0]        upper_bits;

  dve_alu u_alu (
    .req    (alu_req),
    .result (alu_result)
  );

  assign upper_bits = val_r >> GROUP_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    orig_r    <= orig_nxt;
    restart_r <= restart_nxt;
    cnt_r     <= cnt_nxt;
    if (byte_we) begin
      bytes_r[cnt_r] <= val_r[GROUP_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    orig_nxt    = orig_r;
    prev_nxt    = prev_r;
    restart_nxt = restart_r;
    cnt_nxt     = cnt_r;
    byte_we     = 1'b0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    alu_req.op  = ALU_SUB;
    alu_req.a   = val_r;
    alu_req.b   = (delta_mode && !restart_r) ? prev_r : '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt     = in_data.value;
          orig_nxt    = in_data.value;
          restart_nxt = in_data.restart;
          state_nxt   = ST_DIFF;
        end
      end
      ST_DIFF: begin
        // A restart clears the stored value even outside delta mode.
        val_nxt = alu_result;
        if (delta_mode) begin
          prev_nxt = orig_r;
        end else if (restart_r) begin
          prev_nxt = '0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_GROUP;
      end
      ST_GROUP: begin
        alu_req.op = ALU_SHIFT_DEC;
        byte_we    = 1'b1;
        if (upper_bits == '0 || cnt_r == LAST_SLOT) begin
          state_nxt = ST_EMIT;
        end else begin
          val_nxt = alu_result;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Group zero is the final byte; every higher group carries the more flag.
  assign out_data.code_byte = {cnt_r != '0, bytes_r[cnt_r]};
  assign out_data.last_byte = (cnt_r == '0);

endmodule

// ===== src/delta_varint_encoder_top.sv =====
// ----------------------------------------------------------------------------
// delta_varint_encoder_top: bijective base-128 varint encoder, delta option
// Top level: holds the mode register and the encoder sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one 32-bit value
//   and a restart flag per transfer. For each value the output channel
//   (out_valid, out_ready, out_data) delivers one to five transfers, each a
//   varint byte, most significant group first, with last_byte set on the
//   final one. The cfg channel writes the delta_mode bit; it is always ready
//   and should only be written while the encoder is idle.
//   Steps: an item of n bytes is accepted, its difference formed, and its n
//   7-bit groups peeled off one per cycle by the single shared subtractor;
//   the bytes are then drained from the byte store one per cycle while
//   out_ready is high.
//   in_ready is high only while the sequencer is idle.
//   When the receiver holds out_ready low the current byte simply stays
//   on the port; nothing is lost or repeated.
//   Reset clears delta_mode, the stored previous value and the sequencer.
// ----------------------------------------------------------------------------
module delta_varint_encoder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dve_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dve_pkg::out_item_t    out_data
);
  import dve_pkg::*;

  logic delta_mode_r;

  // The mode register accepts a transfer in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      delta_mode_r <= cfg_data;
    end
  end

  // The sequencer owns the previous value, the group loop and the byte store.
  dve_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .delta_mode (delta_mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for delta_varint_encoder_top
// Drives 32-bit values with restart flags through the input channel and
// toggles delta_mode between phases. A scoreboard class predicts the
// bijective base-128 byte stream of every accepted value and compares it
// byte by byte with what the output channel delivers.
// ----------------------------------------------------------------------------

// Scoreboard: holds its own copy of the mode bit and of the stored value,
// and a queue of the bytes that the encoder still owes.
class varint_scoreboard;
  localparam logic [7:0] MORE_BIT = 8'h80;

  bit                   delta_mode;
  logic [31:0]          last_value;
  dve_pkg::out_item_t   pending_bytes[$];
  int unsigned          errors;

  function void clear();
    delta_mode = 1'b0;
    last_value = '0;
    pending_bytes.delete();
    errors = 0;
  endfunction

  // Called at the edge where an input transfer completes.
  function void note_value(dve_pkg::in_item_t item);
    logic [31:0]        coded;
    logic [31:0]        rest;
    logic [7:0]         groups[dve_pkg::MAX_BYTES];
    int                 n;
    dve_pkg::out_item_t exp_byte;
    if (item.restart) begin
      last_value = '0;
    end
    if (delta_mode) begin
      coded      = item.value - last_value;
      last_value = item.value;
    end else begin
      coded = item.value;
    end
    // Lowest group goes in as is; every higher group is reduced by one.
    groups[0] = {1'b0, coded[6:0]};
    n         = 1;
    rest      = coded >> dve_pkg::GROUP_BITS;
    while (rest != 0 && n < dve_pkg::MAX_BYTES) begin
      rest      = rest - 1;
      groups[n] = MORE_BIT | {1'b0, rest[6:0]};
      n++;
      rest      = rest >> dve_pkg::GROUP_BITS;
    end
    for (int k = n - 1; k >= 0; k--) begin
      exp_byte.code_byte = groups[k];
      exp_byte.last_byte = (k == 0);
      pending_bytes.push_back(exp_byte);
    end
  endfunction

  function void check_byte(dve_pkg::out_item_t got);
    dve_pkg::out_item_t exp_byte;
    if (pending_bytes.size() == 0) begin
      errors++;
      $display("%0t: unexpected byte, expected none, actual code_byte=%02h last_byte=%0b",
               $time, got.code_byte, got.last_byte);
      return;
    end
    exp_byte = pending_bytes.pop_front();
    if (got.code_byte !== exp_byte.code_byte) begin
      errors++;
      $display("%0t: code_byte mismatch, expected %02h, actual %02h",
               $time, exp_byte.code_byte, got.code_byte);
    end
    if (got.last_byte !== exp_byte.last_byte) begin
      errors++;
      $display("%0t: last_byte mismatch, expected %0b, actual %0b",
               $time, exp_byte.last_byte, got.last_byte);
    end
  endfunction
endclass

module testbench;
  import dve_pkg::*;

  // Covers the worst item inside the block plus margin.
  localparam int DRAIN_CYCLES = 16;
  // Byte count at which the receiver goes quiet for a long stretch.
  localparam int HOLD_AT_BYTE = 150;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  varint_scoreboard sb;

  // When set, neither side inserts idle cycles.
  bit          no_idle;
  bit          rx_enable;
  int unsigned bytes_seen;

  // Largest value of each encoded length, used for boundary stimulus.
  logic [31:0] length_limits[4] = '{32'd127, 32'd16511, 32'd2113663, 32'd270549119};

  delta_varint_encoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Offer one value. The gap before it is drawn per item; with no gap the
  // valid simply stays high from the previous transfer so it is never
  // dropped and raised in the same time step.
  task automatic send_value(input logic [31:0] value, input logic restart);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.value   = value;
    in_data.restart = restart;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    // The transfer has happened at this edge; predict its bytes now.
    sb.note_value(in_data);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The mode register may only change while the encoder is idle, so the
  // input is parked and every owed byte collected before the write.
  task automatic set_mode(input bit mode);
    stop_input();
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = mode;
    do @(posedge clk); while (!cfg_ready);
    sb.delta_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random value shaped to hit every encoded length, the length edges, and
  // in delta mode differences that are small, zero or wrap below zero.
  function automatic logic [31:0] pick_value();
    logic [31:0] edge_val;
    case ($urandom_range(0, 6))
      0, 1: pick_value = $urandom();
      2: begin
        edge_val   = length_limits[$urandom_range(0, 3)];
        pick_value = edge_val + $urandom_range(0, 2) - 1;
      end
      3: pick_value = $urandom_range(0, 300);
      4: pick_value = sb.last_value + $urandom_range(0, 20000);
      5: pick_value = sb.last_value - $urandom_range(0, 200);
      default: pick_value = 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  // Receiver: draws a stall per byte, and once in the run holds out_ready
  // low for a long stretch so the encoder backs up and stalls its input.
  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    wait (rx_enable);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (!held && bytes_seen >= HOLD_AT_BYTE) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_byte(out_data);
      bytes_seen++;
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb         = new();
    sb.clear();
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    no_idle    = 1'b0;
    rx_enable  = 1'b0;
    bytes_seen = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n     = 1'b1;
    rx_enable = 1'b1;

    // Direct encoding at every length boundary, plus the extremes and
    // alternating bit patterns. Restart in this mode still clears the
    // stored value.
    set_mode(1'b0);
    send_value(32'd0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      send_value(length_limits[i], 1'b0);
      send_value(length_limits[i] + 1, 1'b0);
    end
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h5555_5555, 1'b1);
    send_value(32'hAAAA_AAAA, 1'b0);

    // Delta mode: plain difference, wrap below zero, zero difference,
    // restart in the middle, and the largest wrapped difference.
    set_mode(1'b1);
    send_value(32'd1000, 1'b0);
    send_value(32'd500, 1'b0);
    send_value(32'd500, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'd0, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b1);
    send_value(32'd0, 1'b1);
    send_value(32'd1, 1'b0);
    send_value(32'd0, 1'b0);

    // Stored value must survive a pass through direct mode untouched.
    set_mode(1'b0);
    send_value(32'd77, 1'b0);
    set_mode(1'b1);
    send_value(32'd5, 1'b0);

    // Random phases, alternating the mode; the third runs without idling
    // on either side.
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0] ? 1'b0 : 1'b1);
      no_idle = (phase == 2);
      for (int n = 0; n < 47; n++) begin
        send_value(pick_value(), ($urandom_range(0, 9) == 0));
      end
    end
    no_idle = 1'b0;

    stop_input();
    wait_drained();
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
